@@ hw/rtl/tbc_pkg.sv @@
package tbc_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int WEIGHT_FRAC_BITS = 16;
	// integer bits of a weight, sign included
	localparam int INT_BITS         = 4;
	localparam int WEIGHT_WIDTH     = WEIGHT_FRAC_BITS + INT_BITS;

	localparam int EDGE_W = COORD_WIDTH + 1;
	localparam int DOT_W  = 2 * EDGE_W + 2;
	localparam int LO_W   = DOT_W / 2;
	localparam int HI_W   = DOT_W - LO_W;
	localparam int PROD_W = 2 * DOT_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int DSR_W  = NUM_W + INT_BITS - 1;
	localparam int REM_W  = DSR_W + 1;

	localparam int FRONT_STAGES = 5;
	localparam int N_STAGES     = FRONT_STAGES + WEIGHT_WIDTH + 1;

	typedef logic signed [COORD_WIDTH-1:0]  coord_t;
	typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
	typedef logic signed [EDGE_W-1:0]       edge_t;
	typedef logic signed [DOT_W-1:0]        dot_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic signed [NUM_W-1:0]        num_t;

	typedef struct packed {
		logic [REM_W-1:0]        rem_v;
		logic [REM_W-1:0]        rem_w;
		logic [WEIGHT_WIDTH-1:0] quo_v;
		logic [WEIGHT_WIDTH-1:0] quo_w;
		logic [DSR_W-1:0]        dsr;
		logic                    neg_v;
		logic                    neg_w;
		logic                    big_v;
		logic                    big_w;
		logic                    degen;
	} div_t;

endpackage

@@ hw/rtl/tbc_front.sv @@
module tbc_front (
	input  logic                              clk,
	input  logic [tbc_pkg::FRONT_STAGES-1:0] en,
	input  tbc_pkg::coord_t                   coord [12],
	output tbc_pkg::div_t                     div_s5
);
	import tbc_pkg::*;

	// operand pairs: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
	localparam int MA [6] = '{0, 1, 2, 1, 0, 1};
	localparam int MB [6] = '{2, 1, 3, 4, 4, 3};

	edge_t                          edge_s1 [3][3];
	dot_t                           dot_s2  [5];
	logic signed [DOT_W+HI_W-1:0]   hi_s3   [6];
	logic signed [DOT_W+LO_W:0]     lo_s3   [6];
	prod_t                          prod_c  [6];
	num_t                           den_s4, nv_s4, nw_s4;
	logic [NUM_W-1:0]               mag_v, mag_w, mag_d;

	function automatic dot_t dot3(input edge_t a0, a1, a2, b0, b1, b2);
		logic signed [2*EDGE_W-1:0] p0, p1, p2;
		p0 = a0 * b0;
		p1 = a1 * b1;
		p2 = a2 * b2;
		return DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
	endfunction

	function automatic logic [NUM_W-1:0] mag(input num_t x);
		return x[NUM_W-1] ? NUM_W'(-x) : NUM_W'(x);
	endfunction

	// edges from vertex A: B-A, C-A, P-A
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int e = 0; e < 3; e++) begin
				for (int i = 0; i < 3; i++) begin
					edge_s1[e][i] <= EDGE_W'(coord[3*(e+1)+i]) - EDGE_W'(coord[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dot_s2[0] <= dot3(edge_s1[0][0], edge_s1[0][1], edge_s1[0][2],
				edge_s1[0][0], edge_s1[0][1], edge_s1[0][2]);
			dot_s2[1] <= dot3(edge_s1[0][0], edge_s1[0][1], edge_s1[0][2],
				edge_s1[1][0], edge_s1[1][1], edge_s1[1][2]);
			dot_s2[2] <= dot3(edge_s1[1][0], edge_s1[1][1], edge_s1[1][2],
				edge_s1[1][0], edge_s1[1][1], edge_s1[1][2]);
			dot_s2[3] <= dot3(edge_s1[2][0], edge_s1[2][1], edge_s1[2][2],
				edge_s1[0][0], edge_s1[0][1], edge_s1[0][2]);
			dot_s2[4] <= dot3(edge_s1[2][0], edge_s1[2][1], edge_s1[2][2],
				edge_s1[1][0], edge_s1[1][1], edge_s1[1][2]);
		end
	end

	// split the right operand: signed high half, unsigned low half
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 6; i++) begin
				hi_s3[i] <= dot_s2[MA[i]] * $signed(dot_s2[MB[i]][DOT_W-1:LO_W]);
				lo_s3[i] <= dot_s2[MA[i]] * $signed({1'b0, dot_s2[MB[i]][LO_W-1:0]});
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			prod_c[i] = (PROD_W'(hi_s3[i]) <<< LO_W) + PROD_W'(lo_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			den_s4 <= NUM_W'(prod_c[0]) - NUM_W'(prod_c[1]);
			nv_s4  <= NUM_W'(prod_c[2]) - NUM_W'(prod_c[3]);
			nw_s4  <= NUM_W'(prod_c[4]) - NUM_W'(prod_c[5]);
		end
	end

	assign mag_v = mag(nv_s4);
	assign mag_w = mag(nw_s4);
	assign mag_d = mag(den_s4);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			div_s5.rem_v <= REM_W'(mag_v);
			div_s5.rem_w <= REM_W'(mag_w);
			div_s5.quo_v <= '0;
			div_s5.quo_w <= '0;
			div_s5.dsr   <= DSR_W'(mag_d) << (INT_BITS - 1);
			div_s5.neg_v <= nv_s4[NUM_W-1] != den_s4[NUM_W-1];
			div_s5.neg_w <= nw_s4[NUM_W-1] != den_s4[NUM_W-1];
			// quotient would not fit in the weight's integer bits
			div_s5.big_v <= REM_W'(mag_v) >= (REM_W'(mag_d) << INT_BITS);
			div_s5.big_w <= REM_W'(mag_w) >= (REM_W'(mag_d) << INT_BITS);
			div_s5.degen <= den_s4 == '0;
		end
	end

endmodule

@@ hw/rtl/tbc_div_cell.sv @@
module tbc_div_cell (
	input  logic          clk,
	input  logic          en,
	input  tbc_pkg::div_t din,
	output tbc_pkg::div_t dout
);
	import tbc_pkg::*;

	logic [REM_W-1:0] dsr_x, diff_v, diff_w;
	logic             ge_v, ge_w;
	div_t             nxt;

	assign dsr_x  = {1'b0, din.dsr};
	assign ge_v   = din.rem_v >= dsr_x;
	assign ge_w   = din.rem_w >= dsr_x;
	assign diff_v = din.rem_v - dsr_x;
	assign diff_w = din.rem_w - dsr_x;

	// one quotient bit per lane; unless a big flag is set, the remainder stays below twice the divisor
	always_comb begin
		nxt       = din;
		nxt.rem_v = (ge_v ? diff_v : din.rem_v) << 1;
		nxt.rem_w = (ge_w ? diff_w : din.rem_w) << 1;
		nxt.quo_v = {din.quo_v[WEIGHT_WIDTH-2:0], ge_v};
		nxt.quo_w = {din.quo_w[WEIGHT_WIDTH-2:0], ge_w};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

@@ hw/rtl/tbc_back.sv @@
module tbc_back (
	input  logic             clk,
	input  logic             en,
	input  tbc_pkg::div_t    din,
	output tbc_pkg::weight_t weight_u,
	output tbc_pkg::weight_t weight_v,
	output tbc_pkg::weight_t weight_w,
	output logic             degenerate,
	output logic             saturated
);
	import tbc_pkg::*;

	localparam logic [WEIGHT_WIDTH-1:0] LIM_POS = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
	localparam logic [WEIGHT_WIDTH-1:0] LIM_NEG = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
	localparam logic signed [WEIGHT_WIDTH+1:0] ONE = (WEIGHT_WIDTH+2)'(1) <<< WEIGHT_FRAC_BITS;

	logic [WEIGHT_WIDTH-1:0]       lim_v, lim_w, mag_v, mag_w;
	logic                          clip_v, clip_w, clip_u;
	weight_t                       val_v, val_w, val_u;
	logic signed [WEIGHT_WIDTH+1:0] u_full;

	always_comb begin
		lim_v  = din.neg_v ? LIM_NEG : LIM_POS;
		lim_w  = din.neg_w ? LIM_NEG : LIM_POS;
		clip_v = din.big_v || (din.quo_v > lim_v);
		clip_w = din.big_w || (din.quo_w > lim_w);
		mag_v  = clip_v ? lim_v : din.quo_v;
		mag_w  = clip_w ? lim_w : din.quo_w;
		val_v  = din.neg_v ? -$signed(mag_v) : $signed(mag_v);
		val_w  = din.neg_w ? -$signed(mag_w) : $signed(mag_w);
		u_full = ONE - (WEIGHT_WIDTH+2)'(val_v) - (WEIGHT_WIDTH+2)'(val_w);
		clip_u = (u_full[WEIGHT_WIDTH+1:WEIGHT_WIDTH-1] != '0)
			&& (u_full[WEIGHT_WIDTH+1:WEIGHT_WIDTH-1] != '1);
		if (!clip_u) begin
			val_u = u_full[WEIGHT_WIDTH-1:0];
		end else if (u_full[WEIGHT_WIDTH+1]) begin
			val_u = $signed(LIM_NEG);
		end else begin
			val_u = $signed(LIM_POS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (din.degen) begin
				weight_u   <= '0;
				weight_v   <= '0;
				weight_w   <= '0;
				degenerate <= 1'b1;
				saturated  <= 1'b0;
			end else begin
				weight_u   <= val_u;
				weight_v   <= val_v;
				weight_w   <= val_w;
				degenerate <= 1'b0;
				saturated  <= clip_u || clip_v || clip_w;
			end
		end
	end

endmodule

@@ hw/rtl/triangle_barycentric_coords.sv @@
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_stall   | vertex_a/b/c_x/y/z, query_x/y/z (Q8.8)
// out      | out_valid / out_stall | weight_u/v/w (Q3.16), degenerate, saturated
//
// One transaction per cycle unless out_stall holds the pipeline; 5 front stages (edges, dot
// products, split multiplies, determinant/numerators, magnitudes), 20 divider
// cells giving one quotient bit each, one output stage.
// Each stage holds its own valid bit; a stall only backs up into full stages,
// so bubbles close up. Reset clears the valid bits only.
module triangle_barycentric_coords (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tbc_pkg::coord_t  vertex_a_x,
	input  tbc_pkg::coord_t  vertex_a_y,
	input  tbc_pkg::coord_t  vertex_a_z,
	input  tbc_pkg::coord_t  vertex_b_x,
	input  tbc_pkg::coord_t  vertex_b_y,
	input  tbc_pkg::coord_t  vertex_b_z,
	input  tbc_pkg::coord_t  vertex_c_x,
	input  tbc_pkg::coord_t  vertex_c_y,
	input  tbc_pkg::coord_t  vertex_c_z,
	input  tbc_pkg::coord_t  query_x,
	input  tbc_pkg::coord_t  query_y,
	input  tbc_pkg::coord_t  query_z,
	output logic             out_valid,
	input  logic             out_stall,
	output tbc_pkg::weight_t weight_u,
	output tbc_pkg::weight_t weight_v,
	output tbc_pkg::weight_t weight_w,
	output logic             degenerate,
	output logic             saturated
);
	import tbc_pkg::*;

	logic [N_STAGES-1:0] valid_q;
	logic [N_STAGES-1:0] rdy;
	coord_t              coord [12];
	div_t                chain [WEIGHT_WIDTH+1];

	assign coord = '{vertex_a_x, vertex_a_y, vertex_a_z,
		vertex_b_x, vertex_b_y, vertex_b_z,
		vertex_c_x, vertex_c_y, vertex_c_z,
		query_x, query_y, query_z};

	// a stage may load when it is empty or its content moves on
	always_comb begin
		rdy[N_STAGES-1] = !valid_q[N_STAGES-1] || !out_stall;
		for (int k = N_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < N_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = valid_q[N_STAGES-1];

	tbc_front u_front (
		.clk    (clk),
		.en     (rdy[FRONT_STAGES-1:0]),
		.coord  (coord),
		.div_s5 (chain[0])
	);

	for (genvar k = 0; k < WEIGHT_WIDTH; k++) begin : g_cell
		tbc_div_cell u_cell (
			.clk  (clk),
			.en   (rdy[FRONT_STAGES+k]),
			.din  (chain[k]),
			.dout (chain[k+1])
		);
	end

	tbc_back u_back (
		.clk        (clk),
		.en         (rdy[N_STAGES-1]),
		.din        (chain[WEIGHT_WIDTH]),
		.weight_u   (weight_u),
		.weight_v   (weight_v),
		.weight_w   (weight_w),
		.degenerate (degenerate),
		.saturated  (saturated)
	);

endmodule

@@ tb/triangle_barycentric_coords_tb.sv @@
module triangle_barycentric_coords_tb;
	import tbc_pkg::*;

	localparam int ONE       = 1 << WEIGHT_FRAC_BITS;
	localparam int W_HI      = (1 << (WEIGHT_WIDTH - 1)) - 1;
	localparam int W_LO      = -(1 << (WEIGHT_WIDTH - 1));
	localparam int N_RANDOM  = 1700;
	localparam int IDLE_LIM  = 2000;
	localparam int DRAIN_CYC = 40;

	typedef struct {
		weight_t u;
		weight_t v;
		weight_t w;
		logic    degen;
		logic    sat;
	} weights_t;

	typedef struct {
		coord_t   p[12];
		bit       typed;
		weights_t res;
	} vector_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	logic     out_valid;
	logic     out_stall = 1'b0;
	coord_t   cur[12];
	weight_t  weight_u, weight_v, weight_w;
	logic     degenerate, saturated;

	vector_t  vectors[$];
	weights_t pending_weights[$];
	int       mismatches = 0;
	int       n_out = 0, n_degen = 0, n_sat = 0;
	int       idle_cycles = 0;
	int       stall_left = 0;
	bit       idling_on = 1'b1;
	bit       timed_out = 1'b0;

	initial begin
		for (int i = 0; i < 12; i++) cur[i] = '0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	triangle_barycentric_coords DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_a_x(cur[0]), .vertex_a_y(cur[1]), .vertex_a_z(cur[2]),
		.vertex_b_x(cur[3]), .vertex_b_y(cur[4]), .vertex_b_z(cur[5]),
		.vertex_c_x(cur[6]), .vertex_c_y(cur[7]), .vertex_c_z(cur[8]),
		.query_x(cur[9]), .query_y(cur[10]), .query_z(cur[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.weight_u(weight_u), .weight_v(weight_v), .weight_w(weight_w),
		.degenerate(degenerate), .saturated(saturated)
	);

	function automatic logic signed [127:0] clip_weight(logic signed [127:0] x, ref logic sat);
		if (x > W_HI) begin
			sat = 1'b1;
			return W_HI;
		end
		if (x < W_LO) begin
			sat = 1'b1;
			return W_LO;
		end
		return x;
	endfunction

	// exact Gram-determinant solve, quotients truncated toward zero
	function automatic weights_t barycentric_weights(coord_t c[12]);
		logic signed [127:0] e0[3], e1[3], e2[3];
		logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu;
		logic sat;
		weights_t r;
		sat = 1'b0;
		d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
		for (int i = 0; i < 3; i++) begin
			e0[i] = c[3+i];
			e0[i] = e0[i] - c[i];
			e1[i] = c[6+i];
			e1[i] = e1[i] - c[i];
			e2[i] = c[9+i];
			e2[i] = e2[i] - c[i];
			d00 += e0[i] * e0[i];
			d01 += e0[i] * e1[i];
			d11 += e1[i] * e1[i];
			d20 += e2[i] * e0[i];
			d21 += e2[i] * e1[i];
		end
		den = d00 * d11 - d01 * d01;
		if (den == 0) begin
			r.u = '0; r.v = '0; r.w = '0; r.degen = 1'b1; r.sat = 1'b0;
			return r;
		end
		nv = d11 * d20 - d01 * d21;
		nw = d00 * d21 - d01 * d20;
		qv = clip_weight((nv <<< WEIGHT_FRAC_BITS) / den, sat);
		qw = clip_weight((nw <<< WEIGHT_FRAC_BITS) / den, sat);
		qu = clip_weight(ONE - qv - qw, sat);
		r.u = qu[WEIGHT_WIDTH-1:0];
		r.v = qv[WEIGHT_WIDTH-1:0];
		r.w = qw[WEIGHT_WIDTH-1:0];
		r.degen = 1'b0;
		r.sat = sat;
		return r;
	endfunction

	task automatic add_row(input int a[12], input bit typed, input int u, input int v,
			input int w, input bit dg, input bit st);
		vector_t t;
		for (int i = 0; i < 12; i++) t.p[i] = coord_t'(a[i]);
		t.typed = typed;
		t.res.u = weight_t'(u); t.res.v = weight_t'(v); t.res.w = weight_t'(w);
		t.res.degen = dg; t.res.sat = st;
		vectors.push_back(t);
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 2047)) - 16'sd1024;
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	// mostly well-formed triangles, some degenerate ones, some full-range noise
	task automatic add_random_row();
		vector_t t;
		int kind, mode, k;
		kind = $urandom_range(0, 9);
		mode = (kind < 5) ? 1 : (kind < 8) ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 0);
		for (int i = 0; i < 12; i++) t.p[i] = rand_coord(mode);
		if (kind == 5) begin
			k = $urandom_range(0, 4) - 2;
			for (int i = 0; i < 3; i++) begin
				t.p[3+i] = t.p[i] + coord_t'($urandom_range(0, 200)) - 16'sd100;
				t.p[6+i] = coord_t'(t.p[i] + k * (t.p[3+i] - t.p[i]));
			end
		end else if (kind == 6) begin
			// query on the triangle's plane, weights inside or near range
			for (int i = 0; i < 3; i++)
				t.p[9+i] = coord_t'(t.p[i] + (t.p[3+i] - t.p[i]) / 4
					+ (t.p[6+i] - t.p[i]) / 3);
		end
		t.typed = 1'b0;
		vectors.push_back(t);
	endtask

	// input side: hold payload until the transaction completes
	initial begin
		int gap;
		add_row('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0}, 1, ONE, 0, 0, 0, 0);
		add_row('{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0}, 1, 0, ONE, 0, 0, 0);
		add_row('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0}, 1, 0, 0, ONE, 0, 0);
		add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0, 1, 0);
		add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 32767, 32767, 32767}, 1, 0, 0, 0, 1, 0);
		add_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			-32768, -32768, -32768}, 1, 0, 0, 0, 1, 0);
		add_row('{0, 0, 0, 256, 256, 256, 512, 512, 512, 7, 9, 11}, 1, 0, 0, 0, 1, 0);
		add_row('{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 0}, 1, W_LO, W_HI, W_HI, 0, 1);
		add_row('{0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0}, 1, W_HI, W_LO, W_LO, 0, 1);
		add_row('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
			0, 0, 0}, 0, 0, 0, 0, 0, 0);
		add_row('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768,
			-32768, -32768, 32767}, 0, 0, 0, 0, 0, 0);
		add_row('{100, -200, 300, 400, 50, -60, -70, 80, 90, 10, 20, 30}, 0, 0, 0, 0, 0, 0);
		add_row('{0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 0}, 0, 0, 0, 0, 0, 0);
		add_row('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 4096}, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < N_RANDOM; i++) add_random_row();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < vectors.size(); n++) begin
			if (n % 200 == 0) idling_on = !idling_on;
			gap = idling_on ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			for (int i = 0; i < 12; i++) cur[i] <= vectors[n].p[i];
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;
		while (pending_weights.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("Ran %0d triangles (directed and random, with and without idling).", n_out);
		$display("Degenerate results: %0d, saturated results: %0d.", n_degen, n_sat);
		if (mismatches == 0 && pending_weights.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// output side stall pattern
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (out_valid && !out_stall && idling_on)
				stall_left <= $urandom_range(0, 3);
		end
	end

	// scoreboard: queue on input transaction, compare on output transaction
	int row_idx = 0;
	always @(posedge clk) begin
		weights_t e;
		coord_t snap[12];
		if (in_valid && !in_stall) begin
			for (int i = 0; i < 12; i++) snap[i] = cur[i];
			e = barycentric_weights(snap);
			if (vectors[row_idx].typed) e = vectors[row_idx].res;
			pending_weights.push_back(e);
			row_idx++;
		end
		if (out_valid && !out_stall) begin
			n_out++;
			if (pending_weights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction");
			end else begin
				e = pending_weights.pop_front();
				n_degen += e.degen;
				n_sat += e.sat;
				if (weight_u !== e.u || weight_v !== e.v || weight_w !== e.w ||
						degenerate !== e.degen || saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: exp u=%0d v=%0d w=%0d dg=%b st=%b got u=%0d v=%0d w=%0d dg=%b st=%b",
							n_out, e.u, e.v, e.w, e.degen, e.sat,
							weight_u, weight_v, weight_w, degenerate, saturated);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("timeout waiting for transactions");
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
hw/rtl/tbc_pkg.sv
hw/rtl/tbc_front.sv
hw/rtl/tbc_div_cell.sv
hw/rtl/tbc_back.sv
hw/rtl/triangle_barycentric_coords.sv
tb/triangle_barycentric_coords_tb.sv
